FILE: hdl/tsg_pkg.sv
// Shared types and constants for the touch slider gesture detector.
// Holds the sequencer state type, register indexes, field widths and reset values.
// No dependencies.
package tsg_pkg;

	localparam int PAD_W   = 16;
	localparam int TOTAL_W = 19;
	localparam int POS_W   = 26;
	localparam int DVS_W   = 18;
	localparam int QUO_W   = 25;
	localparam int CNT_W   = 5;
	localparam int CFG_W   = 19;
	localparam int IDX_W   = 3;
	localparam int HOLD_W  = 7;
	localparam int STEP_W  = 15;
	localparam int PRESS_W = 8;

	localparam logic [IDX_W-1:0] REG_KEY_PRESS      = 3'd0;
	localparam logic [IDX_W-1:0] REG_KEY_RELEASE    = 3'd1;
	localparam logic [IDX_W-1:0] REG_SLIDER_PRESS   = 3'd2;
	localparam logic [IDX_W-1:0] REG_SLIDER_RELEASE = 3'd3;
	localparam logic [IDX_W-1:0] REG_HOLD_SCANS     = 3'd4;
	localparam logic [IDX_W-1:0] REG_SWIPE_STEP     = 3'd5;

	localparam logic signed [PAD_W-1:0]   KEY_PRESS_RST      = -16'sd250;
	localparam logic signed [PAD_W-1:0]   KEY_RELEASE_RST    = -16'sd150;
	localparam logic signed [TOTAL_W-1:0] SLIDER_PRESS_RST   = -19'sd150;
	localparam logic signed [TOTAL_W-1:0] SLIDER_RELEASE_RST = -19'sd100;
	localparam logic [HOLD_W-1:0]         HOLD_SCANS_RST     = 7'd15;
	localparam logic [STEP_W-1:0]         SWIPE_STEP_RST     = 15'd15;

	localparam logic [PRESS_W-1:0] PRESS_MAX = 8'd255;
	localparam logic [CNT_W-1:0]   DIV_LAST  = 5'(QUO_W - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_PREP,
		ST_DIV,
		ST_SIGN,
		ST_EVAL
	} state_t;

endpackage

FILE: hdl/touch_slider_gesture_detector.sv
// Touch slider and key gesture detector: shared restoring divider for position, hysteresis
// for keys and slider, tap/hold/key/swipe pulses. Depends on tsg_pkg.
// Per accepted input word: load, two divider passes (x, then y) of one prepare step and a
// 25-bit quotient each, sign fix-up, evaluate. A new word is accepted only in idle, after
// the previous result has left evaluate; a stalled result holds the sequencer in evaluate.
// Reset (arst_n low, asynchronous): defaults, no result pending.
module touch_slider_gesture_detector (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [tsg_pkg::IDX_W-1:0]           cfg_index,
	input  logic [tsg_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [tsg_pkg::PAD_W-1:0]    pad_a,
	input  logic signed [tsg_pkg::PAD_W-1:0]    pad_b,
	input  logic signed [tsg_pkg::PAD_W-1:0]    pad_c,
	input  logic signed [tsg_pkg::PAD_W-1:0]    down_key,
	input  logic signed [tsg_pkg::PAD_W-1:0]    pad_d,
	input  logic signed [tsg_pkg::PAD_W-1:0]    pad_e,
	input  logic signed [tsg_pkg::PAD_W-1:0]    up_key,
	input  logic signed [tsg_pkg::PAD_W-1:0]    pad_f,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [tsg_pkg::TOTAL_W-1:0]  pad_total,
	output logic signed [tsg_pkg::POS_W-1:0]    pos_x,
	output logic signed [tsg_pkg::POS_W-1:0]    pos_y,
	output logic                                zero_total,
	output logic                                tap_event,
	output logic                                hold_event,
	output logic                                up_event,
	output logic                                down_event,
	output logic                                swipe_up_event,
	output logic                                swipe_down_event,
	output logic                                slider_on
);

	localparam int PW = tsg_pkg::PAD_W;
	localparam int TW = tsg_pkg::TOTAL_W;
	localparam int YW = tsg_pkg::POS_W;
	localparam int DW = tsg_pkg::DVS_W;
	localparam int QW = tsg_pkg::QUO_W;
	localparam int CW = tsg_pkg::PRESS_W;
	localparam int EW = tsg_pkg::POS_W + 2;

	tsg_pkg::state_t state_q, state_d;

	// configuration registers
	logic signed [PW-1:0]            key_press_q, key_release_q;
	logic signed [TW-1:0]            sld_press_q, sld_release_q;
	logic [tsg_pkg::HOLD_W-1:0]      hold_scans_q;
	logic [tsg_pkg::STEP_W-1:0]      swipe_step_q;

	// captured word
	logic signed [PW-1:0] a_q, b_q, c_q, d_q, e_q, f_q, uk_q, dk_q;

	// datapath
	logic signed [TW-1:0] total_q;
	logic signed [YW-1:0] num_x_q, num_y_q;
	logic signed [YW-1:0] x_q, y_q;
	logic [QW-1:0]        quo_q, qx_q;
	logic [DW-1:0]        rem_q, dvs_q;
	logic [tsg_pkg::CNT_W-1:0] cnt_q;
	logic                 sel_q;

	// gesture state
	logic                 up_on_q, down_on_q, held_q;
	logic [CW-1:0]        press_q;
	logic signed [YW-1:0] ref_q;

	// output register
	logic                 out_valid_q;

	logic signed [TW-1:0] total_c;
	logic signed [YW-1:0] dx_c, dy_c;
	logic signed [YW-1:0] num_sel_c;
	logic [DW+1:0]        trial_c;
	logic                 out_free_c;
	logic                 zero_c;
	logic signed [YW-1:0] qx_s_c, qy_s_c;

	logic                 up_ev_c, up_on_c, dn_ev_c, dn_on_c;
	logic signed [YW-1:0] r0_c, r1_c, r2_c;
	logic signed [EW-1:0] step_c;
	logic                 sw_up_c, sw_dn_c, track_c;
	logic                 tap_c, held_c, hold_c;
	logic [CW-1:0]        press_c;

	assign in_ready   = (state_q == tsg_pkg::ST_IDLE);
	assign out_valid  = out_valid_q;
	assign out_free_c = !out_valid_q || out_ready;

	assign total_c = TW'(a_q) + TW'(b_q) + TW'(c_q) + TW'(d_q) + TW'(e_q) + TW'(f_q);
	assign dx_c    = YW'(a_q) + YW'(e_q) - YW'(c_q) - YW'(f_q);
	assign dy_c    = YW'(b_q) + YW'(c_q) + YW'(e_q) - YW'(a_q) - YW'(d_q) - YW'(f_q);

	assign num_sel_c = sel_q ? num_y_q : num_x_q;
	assign trial_c   = {1'b0, rem_q, quo_q[QW-1]} - {2'b00, dvs_q};

	assign zero_c = (total_q == '0);
	assign qx_s_c = (num_x_q[YW-1] ^ total_q[TW-1]) ? -YW'(qx_q) : YW'(qx_q);
	assign qy_s_c = (num_y_q[YW-1] ^ total_q[TW-1]) ? -YW'(quo_q) : YW'(quo_q);

	always_comb begin
		up_ev_c = 1'b0;
		up_on_c = up_on_q;
		if (uk_q < key_press_q && !up_on_q) begin
			up_ev_c = 1'b1;
			up_on_c = 1'b1;
		end else if (uk_q > key_release_q && up_on_q) begin
			up_on_c = 1'b0;
		end
		dn_ev_c = 1'b0;
		dn_on_c = down_on_q;
		if (dk_q < key_press_q && !down_on_q) begin
			dn_ev_c = 1'b1;
			dn_on_c = 1'b1;
		end else if (dk_q > key_release_q && down_on_q) begin
			dn_on_c = 1'b0;
		end

		step_c  = $signed({{(EW-tsg_pkg::STEP_W){1'b0}}, swipe_step_q});
		r0_c    = (press_q == CW'(1)) ? y_q : ref_q;
		track_c = (press_q > CW'(hold_scans_q));
		sw_up_c = track_c && (EW'(y_q) > EW'(r0_c) + step_c);
		r1_c    = sw_up_c ? y_q : r0_c;
		sw_dn_c = track_c && (EW'(y_q) < EW'(r1_c) - step_c);
		r2_c    = sw_dn_c ? y_q : r1_c;

		tap_c  = (total_q < sld_press_q) && !held_q;
		held_c = (held_q || tap_c) && !(total_q > sld_release_q);
		if (held_c) begin
			press_c = (press_q == tsg_pkg::PRESS_MAX) ? press_q : press_q + CW'(1);
			hold_c  = (press_c == CW'(hold_scans_q));
		end else begin
			press_c = '0;
			hold_c  = 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tsg_pkg::ST_IDLE: if (in_valid) state_d = tsg_pkg::ST_LOAD;
			tsg_pkg::ST_LOAD: state_d = tsg_pkg::ST_PREP;
			tsg_pkg::ST_PREP: state_d = tsg_pkg::ST_DIV;
			tsg_pkg::ST_DIV: begin
				if (cnt_q == tsg_pkg::DIV_LAST)
					state_d = sel_q ? tsg_pkg::ST_SIGN : tsg_pkg::ST_PREP;
			end
			tsg_pkg::ST_SIGN: state_d = tsg_pkg::ST_EVAL;
			tsg_pkg::ST_EVAL: if (out_free_c) state_d = tsg_pkg::ST_IDLE;
			default: state_d = tsg_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_press_q   <= tsg_pkg::KEY_PRESS_RST;
			key_release_q <= tsg_pkg::KEY_RELEASE_RST;
			sld_press_q   <= tsg_pkg::SLIDER_PRESS_RST;
			sld_release_q <= tsg_pkg::SLIDER_RELEASE_RST;
			hold_scans_q  <= tsg_pkg::HOLD_SCANS_RST;
			swipe_step_q  <= tsg_pkg::SWIPE_STEP_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				tsg_pkg::REG_KEY_PRESS:      key_press_q   <= $signed(cfg_data[PW-1:0]);
				tsg_pkg::REG_KEY_RELEASE:    key_release_q <= $signed(cfg_data[PW-1:0]);
				tsg_pkg::REG_SLIDER_PRESS:   sld_press_q   <= $signed(cfg_data[TW-1:0]);
				tsg_pkg::REG_SLIDER_RELEASE: sld_release_q <= $signed(cfg_data[TW-1:0]);
				tsg_pkg::REG_HOLD_SCANS:     hold_scans_q  <= cfg_data[tsg_pkg::HOLD_W-1:0];
				tsg_pkg::REG_SWIPE_STEP:     swipe_step_q  <= cfg_data[tsg_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			tsg_pkg::ST_IDLE: begin
				if (in_valid) begin
					a_q  <= pad_a;
					b_q  <= pad_b;
					c_q  <= pad_c;
					d_q  <= pad_d;
					e_q  <= pad_e;
					f_q  <= pad_f;
					uk_q <= up_key;
					dk_q <= down_key;
				end
			end
			tsg_pkg::ST_LOAD: begin
				total_q <= total_c;
				num_x_q <= (dx_c <<< 7) - dx_c;
				num_y_q <= (dy_c <<< 7) - dy_c;
				sel_q   <= 1'b0;
			end
			tsg_pkg::ST_PREP: begin
				dvs_q <= total_q[TW-1] ? DW'(-total_q) : DW'(total_q);
				quo_q <= num_sel_c[YW-1] ? QW'(-num_sel_c) : QW'(num_sel_c);
				rem_q <= '0;
				cnt_q <= '0;
			end
			tsg_pkg::ST_DIV: begin
				if (!trial_c[DW+1]) begin
					rem_q <= trial_c[DW-1:0];
					quo_q <= {quo_q[QW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[DW-2:0], quo_q[QW-1]};
					quo_q <= {quo_q[QW-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == tsg_pkg::DIV_LAST && !sel_q) begin
					qx_q  <= trial_c[DW+1] ? {quo_q[QW-2:0], 1'b0} : {quo_q[QW-2:0], 1'b1};
					sel_q <= 1'b1;
				end
			end
			tsg_pkg::ST_SIGN: begin
				x_q <= zero_c ? '0 : qx_s_c;
				y_q <= zero_c ? '0 : qy_s_c;
			end
			tsg_pkg::ST_EVAL: begin
				if (out_free_c) begin
					pad_total        <= total_q;
					pos_x            <= x_q;
					pos_y            <= y_q;
					zero_total       <= zero_c;
					tap_event        <= tap_c;
					hold_event       <= hold_c;
					up_event         <= up_ev_c;
					down_event       <= dn_ev_c;
					swipe_up_event   <= sw_up_c;
					swipe_down_event <= sw_dn_c;
					slider_on        <= held_c;
				end
			end
			default: ;
		endcase
	end

	// gesture state and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_on_q     <= 1'b0;
			down_on_q   <= 1'b0;
			held_q      <= 1'b0;
			press_q     <= '0;
			ref_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == tsg_pkg::ST_EVAL && out_free_c) begin
				up_on_q     <= up_on_c;
				down_on_q   <= dn_on_c;
				held_q      <= held_c;
				press_q     <= press_c;
				ref_q       <= r2_c;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
